@@ rtl/core/kprc_pkg.sv @@
// Shared types and constants of the key press record controller.
`default_nettype none
package kprc_pkg;

	localparam int unsigned POSITIONS = 3;
	localparam int unsigned INDEX_MAX = 999;

	localparam int unsigned AGE_W = 16;
	localparam int unsigned IDX_W = 10;
	localparam int unsigned POS_W = 2;
	localparam int unsigned DEB_W = 8;
	localparam int unsigned CFG_DATA_W = 16;
	localparam int unsigned CFG_IDX_W = 2;
	localparam int unsigned SLOT_W = (POSITIONS > 1) ? $clog2(POSITIONS) : 1;

	localparam logic [AGE_W-1:0] AGE_MAX = {AGE_W{1'b1}};

	// Register indexes of the configuration port.
	localparam logic [CFG_IDX_W-1:0] REG_DEBOUNCE = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_TIMEOUT = 2'd2;

	localparam logic [DEB_W-1:0] DEBOUNCE_RST = 8'd30;
	localparam logic [AGE_W-1:0] LONG_PRESS_RST = 16'd2000;
	localparam logic [AGE_W-1:0] TIMEOUT_RST = 16'd30000;

	typedef struct packed {
		logic edge_seen;
		logic pin_low;
		logic target_reached;
		logic storage_busy;
		logic start_ok;
	} kprc_in_t;

	typedef struct packed {
		logic             start_record;
		logic             start_failed;
		logic             stop_capture;
		logic             finalize_capture;
		logic             position_changed;
		logic [POS_W-1:0] position;
		logic [IDX_W-1:0] file_index;
		logic             recording;
		logic [AGE_W-1:0] record_ms;
		logic             key_held;
	} kprc_out_t;

endpackage
`default_nettype wire

@@ rtl/core/kprc_in_if.sv @@
// Valid/ready channel that carries one tick item into the controller.
`default_nettype none
interface kprc_in_if;
	import kprc_pkg::*;

	logic     valid;
	logic     ready;
	kprc_in_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/kprc_out_if.sv @@
// Valid/ready channel that carries one result item out of the controller.
`default_nettype none
interface kprc_out_if;
	import kprc_pkg::*;

	logic      valid;
	logic      ready;
	kprc_out_t data;

	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

@@ rtl/core/key_press_record_controller_top.sv @@
// Key press record controller: debounce, short/long press and record timer.
// Usage: every millisecond one tick item is offered on key_in carrying the
// falling-edge flag, the pin level and the storage status flags. For every
// accepted item exactly one result item appears on rec_out with the start,
// stop and position events of that tick plus the current position, file
// index, record timer and key state.
// The result of an accepted item is registered and is valid in the cycle
// after it is accepted. Throughput is one item per cycle while the
// receiver takes every result; all state is updated by a single pass of
// counter and compare logic into the result register.
// When the receiver stalls, the result is held in the output register and
// key_in.ready stays high only if that result is taken in the same cycle,
// so no result is dropped and a new item still enters while one is taken.
// Reset clears all counters and flags, sets the position to 1, all file
// indexes to 0 and loads the default debounce, long-press and timeout
// values. Configuration is written through cfg_we/cfg_index/cfg_data while
// the block is idle; writes to an unused index are ignored.
`default_nettype none
module key_press_record_controller_top (
	input  wire logic                               clk,
	input  wire logic                               arst_n,
	kprc_in_if.sink                                 key_in,
	kprc_out_if.source                              rec_out,
	input  wire logic                               cfg_we,
	input  wire logic [kprc_pkg::CFG_IDX_W-1:0]     cfg_index,
	input  wire logic [kprc_pkg::CFG_DATA_W-1:0]    cfg_data
);
	import kprc_pkg::*;

	// Configuration registers.
	logic [DEB_W-1:0] debounce_q;
	logic [AGE_W-1:0] long_press_q;
	logic [AGE_W-1:0] timeout_q;

	// Controller state.
	logic             edge_pending_q;
	logic [AGE_W-1:0] edge_age_q;
	logic             pressed_q;
	logic             press_handled_q;
	logic [AGE_W-1:0] press_age_q;
	logic             running_q;
	logic [AGE_W-1:0] record_age_q;
	logic [POS_W-1:0] position_q;
	logic [IDX_W-1:0] index_q [POSITIONS];

	logic      out_valid_q;
	kprc_out_t out_q;

	logic accept;

	// Next-state values.
	logic             edge_pending_n;
	logic [AGE_W-1:0] edge_age_n;
	logic             pressed_n;
	logic             press_handled_n;
	logic [AGE_W-1:0] press_age_n;
	logic             running_mid;
	logic             running_n;
	logic [AGE_W-1:0] record_age_n;
	logic [POS_W-1:0] position_n;
	logic [IDX_W-1:0] index_n [POSITIONS];
	logic [SLOT_W-1:0] slot_cur;
	logic [SLOT_W-1:0] slot_new;
	logic [IDX_W:0]   idx_inc;
	logic [IDX_W-1:0] idx_wrap;
	kprc_out_t        res;

	function automatic logic [AGE_W-1:0] age_inc(input logic [AGE_W-1:0] a);
		age_inc = (a == AGE_MAX) ? AGE_MAX : a + 1'b1;
	endfunction

	function automatic logic [SLOT_W-1:0] pos_slot(input logic [POS_W-1:0] p);
		logic [SLOT_W-1:0] s;
		s = '0;
		if (p >= POS_W'(1) && 32'(p) <= POSITIONS) begin
			s = SLOT_W'(p - POS_W'(1));
		end
		pos_slot = s;
	endfunction

	assign accept = key_in.valid && key_in.ready;
	assign key_in.ready = !out_valid_q || rec_out.ready;
	assign rec_out.valid = out_valid_q;
	assign rec_out.data = out_q;

	always_comb begin
		res = '0;
		edge_age_n = age_inc(edge_age_q);
		press_age_n = age_inc(press_age_q);
		record_age_n = running_q ? age_inc(record_age_q) : record_age_q;
		edge_pending_n = edge_pending_q;
		pressed_n = pressed_q;
		press_handled_n = press_handled_q;
		position_n = position_q;
		for (int i = 0; i < POSITIONS; i++) begin
			index_n[i] = index_q[i];
		end
		slot_cur = pos_slot(position_q);
		idx_inc = {1'b0, index_q[slot_cur]} + 1'b1;
		idx_wrap = (32'(idx_inc) > INDEX_MAX) ? IDX_W'(1) : idx_inc[IDX_W-1:0];

		if (key_in.data.edge_seen) begin
			edge_age_n = '0;
			edge_pending_n = 1'b1;
		end

		// Record timer: reaching the target wins over the timeout.
		running_mid = running_q;
		if (running_q) begin
			if (key_in.data.target_reached) begin
				res.stop_capture = 1'b1;
				running_mid = 1'b0;
			end else if (record_age_n >= timeout_q) begin
				res.stop_capture = 1'b1;
				res.finalize_capture = 1'b1;
				running_mid = 1'b0;
			end
		end
		running_n = running_mid;

		if (!pressed_q) begin
			if (edge_pending_n && edge_age_n >= AGE_W'(debounce_q)) begin
				edge_pending_n = 1'b0;
				if (key_in.data.pin_low) begin
					pressed_n = 1'b1;
					press_handled_n = 1'b0;
					press_age_n = edge_age_n;
				end
			end
		end else if (key_in.data.pin_low) begin
			if (!press_handled_q && press_age_n >= long_press_q) begin
				press_handled_n = 1'b1;
				if (!key_in.data.storage_busy) begin
					index_n[slot_cur] = idx_wrap;
					if (key_in.data.start_ok) begin
						running_n = 1'b1;
						record_age_n = '0;
						res.start_record = 1'b1;
					end else begin
						res.start_failed = 1'b1;
					end
				end
			end
		end else if (press_age_n >= AGE_W'(debounce_q)) begin
			// Short press steps the position unless storage is in use.
			if (!press_handled_q && !key_in.data.storage_busy && !running_mid) begin
				position_n = (32'(position_q) >= POSITIONS) ? POS_W'(1)
					: position_q + 1'b1;
				res.position_changed = 1'b1;
			end
			pressed_n = 1'b0;
			press_handled_n = 1'b0;
		end

		slot_new = pos_slot(position_n);
		res.position = position_n;
		res.file_index = index_n[slot_new];
		res.recording = running_n;
		res.record_ms = running_n ? record_age_n : '0;
		res.key_held = pressed_n;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			debounce_q <= DEBOUNCE_RST;
			long_press_q <= LONG_PRESS_RST;
			timeout_q <= TIMEOUT_RST;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_DEBOUNCE: debounce_q <= cfg_data[DEB_W-1:0];
				REG_LONG_PRESS: long_press_q <= cfg_data[AGE_W-1:0];
				REG_TIMEOUT: timeout_q <= cfg_data[AGE_W-1:0];
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			edge_pending_q <= 1'b0;
			edge_age_q <= '0;
			pressed_q <= 1'b0;
			press_handled_q <= 1'b0;
			press_age_q <= '0;
			running_q <= 1'b0;
			record_age_q <= '0;
			position_q <= POS_W'(1);
			for (int i = 0; i < POSITIONS; i++) begin
				index_q[i] <= '0;
			end
		end else if (accept) begin
			edge_pending_q <= edge_pending_n;
			edge_age_q <= edge_age_n;
			pressed_q <= pressed_n;
			press_handled_q <= press_handled_n;
			press_age_q <= press_age_n;
			running_q <= running_n;
			record_age_q <= record_age_n;
			position_q <= position_n;
			for (int i = 0; i < POSITIONS; i++) begin
				index_q[i] <= index_n[i];
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (accept) begin
			out_valid_q <= 1'b1;
		end else if (rec_out.ready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_q <= res;
		end
	end

	a_start_or_fail: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q |-> !(out_q.start_record && out_q.start_failed))
		else $error("start_record and start_failed in the same item");

	a_finalize_stop: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.finalize_capture |-> out_q.stop_capture)
		else $error("finalize without stop");

	a_start_running: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.start_record |-> out_q.recording && out_q.record_ms == '0)
		else $error("started recording does not run from zero");

	a_idle_timer: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && !out_q.recording |-> out_q.record_ms == '0)
		else $error("record time shown while not recording");

	a_accept_loads: assert property (@(posedge clk) disable iff (!arst_n)
		accept |=> out_valid_q && running_q == out_q.recording)
		else $error("result register out of step with timer state");
endmodule
`default_nettype wire

@@ tb/tb_top.sv @@
// Testbench of the key press record controller: directed and random tick items checked against a predictor.
module tb_top;
	timeunit 1ns;
	timeprecision 1ps;
	import kprc_pkg::*;

	logic                  clk;
	logic                  arst_n;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	kprc_in_if  key_in ();
	kprc_out_if rec_out ();

	key_press_record_controller_top dut (
		.clk       (clk),
		.arst_n    (arst_n),
		.key_in    (key_in),
		.rec_out   (rec_out),
		.cfg_we    (cfg_we),
		.cfg_index (cfg_index),
		.cfg_data  (cfg_data)
	);

	// Predictor copy of the timing registers and of the key and record state.
	logic [DEB_W-1:0] debounce_cfg;
	logic [AGE_W-1:0] long_press_cfg;
	logic [AGE_W-1:0] timeout_cfg;
	logic             edge_mark;
	logic             key_down;
	logic             press_done;
	logic             rec_on;
	logic [AGE_W-1:0] edge_ms;
	logic [AGE_W-1:0] press_ms;
	logic [AGE_W-1:0] rec_ms;
	int unsigned      cur_pos;
	int unsigned      file_idx [POSITIONS];

	kprc_out_t   expected_ticks [$];
	int unsigned mismatches;
	int unsigned ticks_sent;
	int unsigned tx_idle_pct;
	int unsigned rx_idle_pct;
	int unsigned stall_requests;

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	initial begin : watchdog
		#2_000_000;
		$display("tb_top: done, errors");
		$finish;
	end

	function automatic logic [AGE_W-1:0] sat_inc(logic [AGE_W-1:0] a);
		return (a == AGE_MAX) ? a : a + 1'b1;
	endfunction

	function automatic bit chance(int unsigned pct);
		return $urandom_range(99) < pct;
	endfunction

	// Advances the key and record state by one millisecond tick.
	function automatic kprc_out_t press_outcome(kprc_in_t t);
		kprc_out_t   r;
		int unsigned slot;
		r = '0;
		edge_ms = sat_inc(edge_ms);
		press_ms = sat_inc(press_ms);
		if (rec_on)
			rec_ms = sat_inc(rec_ms);
		if (t.edge_seen) begin
			edge_ms = '0;
			edge_mark = 1'b1;
		end

		// The capture target wins over a timeout in the same tick.
		if (rec_on) begin
			if (t.target_reached) begin
				r.stop_capture = 1'b1;
				rec_on = 1'b0;
			end else if (rec_ms >= timeout_cfg) begin
				r.stop_capture = 1'b1;
				r.finalize_capture = 1'b1;
				rec_on = 1'b0;
			end
		end

		slot = cur_pos - 1;
		if (!key_down) begin
			if (edge_mark && edge_ms >= debounce_cfg) begin
				edge_mark = 1'b0;
				if (t.pin_low) begin
					key_down = 1'b1;
					press_done = 1'b0;
					press_ms = edge_ms;
				end
			end
		end else if (t.pin_low) begin
			if (!press_done && press_ms >= long_press_cfg) begin
				press_done = 1'b1;
				// A busy store swallows the attempt without touching the index.
				if (!t.storage_busy) begin
					file_idx[slot] = (file_idx[slot] >= INDEX_MAX) ? 1 : file_idx[slot] + 1;
					if (t.start_ok) begin
						rec_on = 1'b1;
						rec_ms = '0;
						r.start_record = 1'b1;
					end else begin
						r.start_failed = 1'b1;
					end
				end
			end
		end else if (press_ms >= debounce_cfg) begin
			if (!press_done && !t.storage_busy && !rec_on) begin
				cur_pos = (cur_pos >= POSITIONS) ? 1 : cur_pos + 1;
				r.position_changed = 1'b1;
			end
			key_down = 1'b0;
			press_done = 1'b0;
		end

		r.position = POS_W'(cur_pos);
		r.file_index = IDX_W'(file_idx[cur_pos - 1]);
		r.recording = rec_on;
		r.record_ms = rec_on ? rec_ms : '0;
		r.key_held = key_down;
		return r;
	endfunction

	function automatic void check_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$display("%0t: %s expected %0d, got %0d", $time, name, want, got);
			mismatches++;
		end
	endfunction

	function automatic void compare_result(kprc_out_t want, kprc_out_t got);
		check_field("start_record", 32'(want.start_record), 32'(got.start_record));
		check_field("start_failed", 32'(want.start_failed), 32'(got.start_failed));
		check_field("stop_capture", 32'(want.stop_capture), 32'(got.stop_capture));
		check_field("finalize_capture", 32'(want.finalize_capture),
			32'(got.finalize_capture));
		check_field("position_changed", 32'(want.position_changed),
			32'(got.position_changed));
		check_field("position", 32'(want.position), 32'(got.position));
		check_field("file_index", 32'(want.file_index), 32'(got.file_index));
		check_field("recording", 32'(want.recording), 32'(got.recording));
		check_field("record_ms", 32'(want.record_ms), 32'(got.record_ms));
		check_field("key_held", 32'(want.key_held), 32'(got.key_held));
	endfunction

	// Results are checked before the item of the same edge enters the predictor.
	always @(posedge clk) begin : result_check
		kprc_out_t want;
		if (arst_n) begin
			if (rec_out.valid && rec_out.ready) begin
				if (expected_ticks.size() == 0) begin
					$display("%0t: result expected none, got %h", $time, rec_out.data);
					mismatches++;
				end else begin
					want = expected_ticks.pop_front();
					compare_result(want, rec_out.data);
				end
			end
			if (key_in.valid && key_in.ready)
				expected_ticks.push_back(press_outcome(key_in.data));
		end
	end

	// Random ready, with a long hold-off each time the stimulus asks for one.
	initial begin : receiver
		int unsigned stall_left;
		int unsigned stalls_done;
		rec_out.ready = 1'b0;
		stall_left = 0;
		stalls_done = 0;
		forever begin
			@(posedge clk);
			if (!arst_n) begin
				rec_out.ready <= 1'b0;
			end else if (stall_left != 0) begin
				rec_out.ready <= 1'b0;
				stall_left--;
			end else if (stalls_done != stall_requests) begin
				stalls_done = stall_requests;
				stall_left = 300;
				rec_out.ready <= 1'b0;
			end else begin
				rec_out.ready <= ($urandom_range(99) >= rx_idle_pct);
			end
		end
	end

	task automatic send_tick(input kprc_in_t t);
		while (chance(tx_idle_pct)) begin
			key_in.valid <= 1'b0;
			@(posedge clk);
		end
		key_in.valid <= 1'b1;
		key_in.data <= t;
		// Ready is stable between edges, so it is looked at on the falling edge.
		@(negedge clk);
		while (!key_in.ready)
			@(negedge clk);
		@(posedge clk);
		ticks_sent++;
	endtask

	task automatic tick(bit e, bit p, bit tg, bit b, bit ok);
		kprc_in_t t;
		t.edge_seen = e;
		t.pin_low = p;
		t.target_reached = tg;
		t.storage_busy = b;
		t.start_ok = ok;
		send_tick(t);
	endtask

	// One press: an edge with the pin low, the hold, then the released pin.
	task automatic key_gesture(int unsigned hold, int unsigned rest, int unsigned ok_pct,
			int unsigned busy_pct, int unsigned target_pct, int unsigned bounce_pct);
		for (int unsigned i = 0; i < hold + rest; i++)
			tick(i == 0 || chance(bounce_pct), i < hold, chance(target_pct),
				chance(busy_pct), chance(ok_pct));
	endtask

	task automatic wait_results();
		key_in.valid <= 1'b0;
		@(negedge clk);
		while (expected_ticks.size() != 0)
			@(negedge clk);
		repeat (2) @(posedge clk);
	endtask

	task automatic apply_timing(logic [DEB_W-1:0] deb, logic [AGE_W-1:0] hold,
			logic [AGE_W-1:0] tmo);
		wait_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_DEBOUNCE;
		cfg_data <= CFG_DATA_W'(deb);
		@(posedge clk);
		cfg_index <= REG_LONG_PRESS;
		cfg_data <= hold;
		@(posedge clk);
		cfg_index <= REG_TIMEOUT;
		cfg_data <= tmo;
		@(posedge clk);
		cfg_we <= 1'b0;
		debounce_cfg = deb;
		long_press_cfg = hold;
		timeout_cfg = tmo;
	endtask

	task automatic test_press_cases();
		apply_timing(8'd1, 16'd2, 16'd5);
		tick(1, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		// An edge while pressed is only looked at after the release.
		tick(1, 1, 0, 0, 0);
		tick(0, 0, 0, 0, 0);
		tick(0, 1, 0, 0, 0);
		// A short press while the record timer runs keeps the position.
		tick(0, 0, 0, 0, 0);
		// Target and timeout in one tick: stop without finalize.
		tick(1, 1, 1, 0, 0);
		tick(0, 1, 0, 1, 0);
		tick(0, 1, 0, 1, 1);
		tick(0, 0, 0, 0, 1);
		tick(1, 1, 0, 0, 0);
		tick(0, 1, 0, 0, 0);
		tick(0, 1, 0, 0, 0);
		tick(0, 0, 0, 0, 0);
		tick(1, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 0, 0, 1, 1);
		tick(1, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 0, 0, 0, 1);
		tick(1, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 0, 0, 0, 0);
		repeat (4) tick(0, 0, 0, 0, 0);
	endtask

	task automatic test_zero_times();
		apply_timing(8'd0, 16'd0, 16'd0);
		tick(1, 1, 0, 0, 1);
		tick(0, 1, 0, 0, 1);
		tick(0, 0, 0, 0, 0);
		tick(0, 0, 0, 0, 0);
	endtask

	task automatic test_timing_extremes();
		// With the longest debounce and hold times the press is short and steps the position.
		apply_timing(8'd255, 16'hFFFF, 16'hFFFF);
		key_gesture(257, 2, 100, 0, 0, 0);
	endtask

	task automatic test_random_ticks();
		int unsigned deb;
		int unsigned hold;
		int unsigned tmo;
		int unsigned stop_at;
		int unsigned kind;
		for (int s = 0; s < 3; s++) begin
			deb = (s == 0) ? 1 : $urandom_range(1, 6 * s);
			hold = (s == 0) ? 1 : $urandom_range(2, 20);
			tmo = (s == 0) ? 1 : $urandom_range(3, 50);
			apply_timing(DEB_W'(deb), AGE_W'(hold), AGE_W'(tmo));
			stop_at = ticks_sent + 35;
			while (ticks_sent < stop_at) begin
				kind = $urandom_range(99);
				if (kind < 75) begin
					if (chance(50))
						key_gesture($urandom_range(deb + 1, hold + deb), $urandom_range(deb + 1,
							deb + tmo), 80, 10, 4, 5);
					else
						key_gesture($urandom_range(hold + deb + 1, hold + deb + 8),
							$urandom_range(deb + 1, deb + tmo), 80, 10, 4, 5);
				end else if (kind < 90) begin
					// A bouncing press that is released before the debounce time.
					key_gesture($urandom_range(1, deb), $urandom_range(0, 3), 50, 30, 10, 30);
				end else begin
					repeat ($urandom_range(1, 3))
						tick(1'($urandom_range(1)), 1'($urandom_range(1)),
							1'($urandom_range(1)), 1'($urandom_range(1)),
							1'($urandom_range(1)));
				end
			end
		end
	endtask

	task automatic test_output_stall();
		apply_timing(8'd2, 16'd6, 16'd12);
		@(negedge clk);
		stall_requests++;
		@(posedge clk);
		repeat (8)
			key_gesture($urandom_range(3, 10), 3, 80, 10, 5, 5);
		wait_results();
	endtask

	task automatic test_failed_starts();
		apply_timing(8'd1, 16'd1, 16'd1);
		// Every attempt fails to start, so each press only advances the index.
		repeat (10)
			key_gesture(3, 1, 0, 0, 0, 0);
	endtask

	initial begin : stimulus
		debounce_cfg = DEBOUNCE_RST;
		long_press_cfg = LONG_PRESS_RST;
		timeout_cfg = TIMEOUT_RST;
		edge_mark = 1'b0;
		key_down = 1'b0;
		press_done = 1'b0;
		rec_on = 1'b0;
		edge_ms = '0;
		press_ms = '0;
		rec_ms = '0;
		cur_pos = 1;
		foreach (file_idx[i])
			file_idx[i] = 0;
		mismatches = 0;
		ticks_sent = 0;
		stall_requests = 0;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = '0;
		cfg_data = '0;
		key_in.valid = 1'b0;
		key_in.data = '0;
		tx_idle_pct = 34;
		rx_idle_pct = 79;
		repeat (11) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_press_cases();
		test_zero_times();
		test_timing_extremes();
		test_random_ticks();
		test_output_stall();

		wait_results();
		tx_idle_pct = 79;
		rx_idle_pct = 34;
		test_failed_starts();
		test_random_ticks();

		wait_results();
		tx_idle_pct = 0;
		rx_idle_pct = 0;
		test_random_ticks();

		wait_results();
		if (mismatches == 0)
			$display("tb_top: done, clean");
		else
			$display("tb_top: done, errors");
		$finish;
	end

endmodule

@@ files.f @@
rtl/core/kprc_pkg.sv
rtl/core/kprc_in_if.sv
rtl/core/kprc_out_if.sv
rtl/core/key_press_record_controller_top.sv
tb/tb_top.sv
